[hw/rtl/region_walking_frame_allocator_defines.svh]
// assertion macros for the region walking frame allocator
// expects aclk and aresetn in the scope of each use
`ifndef REGION_WALKING_FRAME_ALLOCATOR_DEFINES_SVH
`define REGION_WALKING_FRAME_ALLOCATOR_DEFINES_SVH

// clocked property checked outside reset
`define RWFA_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication checked on the next clock
`define RWFA_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

[hw/rtl/rwfa_pkg.sv]
// shared types and constants for the region walking frame allocator
// no dependencies
package rwfa_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int PAGE_BYTES  = 4096;

    localparam int ADDR_W  = 32;
    localparam int OFF_W   = ADDR_W + 1;
    localparam int ADD_W   = ADDR_W + 2;
    localparam int IDX_W   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W   = $clog2(MAX_REGIONS + 1);

    localparam logic [ADD_W-1:0] PAGE_STEP       = ADD_W'(PAGE_BYTES);
    localparam logic [ADD_W-1:0] PAGE_ALIGN_MASK = ~(ADD_W'(PAGE_BYTES - 1));
    localparam logic [CNT_W-1:0] REGION_LIMIT    = CNT_W'(MAX_REGIONS);

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_ALLOC  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_OOM  = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LEN,
        S_KERN,
        S_GRANT,
        S_SKIPD,
        S_SKIPA,
        S_DONE
    } state_t;

endpackage

[hw/rtl/region_walking_frame_allocator.sv]
// region walking frame allocator: region table, cursor and page walk sequencer
// depends on rwfa_pkg and region_walking_frame_allocator_defines.svh
// clear and append go IDLE to DONE; DONE sets m_valid once the prior result is taken
// allocate: CHECK, LEN per region; KERN, SKIPD, SKIPA per kernel skip; KERN, GRANT to grant
// s_ready returns with m_valid; one shared 34-bit adder and one table read port set the rate
// reset: table count, cursor and kernel_end clear; table entries hold garbage
`include "region_walking_frame_allocator_defines.svh"

module region_walking_frame_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_region_base,
    input  logic [31:0] s_region_length,
    input  logic        s_region_available,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_frame_address,
    output logic [1:0]  m_status
);

    rwfa_pkg::state_t state_reg, state_next;

    logic [rwfa_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [rwfa_pkg::CNT_W-1:0]  cursor_reg, cursor_next;
    logic [rwfa_pkg::OFF_W-1:0]  offset_reg, offset_next;
    logic [rwfa_pkg::OFF_W-1:0]  end_reg, end_next;
    logic [rwfa_pkg::ADD_W-1:0]  acc_reg, acc_next;
    logic [rwfa_pkg::ADDR_W-1:0] kernel_end_reg;
    logic [rwfa_pkg::ADDR_W-1:0] res_addr_reg, res_addr_next;
    rwfa_pkg::status_t           res_status_reg, res_status_next;
    logic                        m_valid_reg, m_valid_next;
    logic [rwfa_pkg::ADDR_W-1:0] m_addr_reg;
    rwfa_pkg::status_t           m_status_reg;

    logic [rwfa_pkg::ADDR_W-1:0] base_mem  [rwfa_pkg::MAX_REGIONS];
    logic [rwfa_pkg::ADDR_W-1:0] len_mem   [rwfa_pkg::MAX_REGIONS];
    logic                        avail_mem [rwfa_pkg::MAX_REGIONS];
    logic [rwfa_pkg::ADDR_W-1:0] rd_base_reg;
    logic [rwfa_pkg::ADDR_W-1:0] rd_len_reg;
    logic                        rd_avail_reg;

    logic [rwfa_pkg::ADD_W-1:0] add_a, add_b, add_sum;
    logic                       add_cin;

    logic accept, table_full, mem_we, out_load;
    logic walk_end, region_skip, page_above;

    assign s_ready         = (state_reg == rwfa_pkg::S_IDLE);
    assign accept          = s_valid && s_ready;
    assign table_full      = (count_reg >= rwfa_pkg::REGION_LIMIT);
    assign mem_we          = accept && (s_action == rwfa_pkg::ACT_APPEND) && !table_full;
    assign out_load        = (state_reg == rwfa_pkg::S_DONE) && (!m_valid_reg || m_ready);
    assign m_valid         = m_valid_reg;
    assign m_frame_address = m_addr_reg;
    assign m_status        = m_status_reg;

    // shared adder operand select
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            rwfa_pkg::S_LEN: begin
                add_a = {1'b0, offset_reg};
                add_b = rwfa_pkg::PAGE_STEP;
            end
            rwfa_pkg::S_KERN: begin
                add_a = {2'b00, rd_base_reg};
                add_b = {1'b0, end_reg};
            end
            rwfa_pkg::S_GRANT: begin
                add_a = {2'b00, rd_base_reg};
                add_b = {1'b0, offset_reg};
            end
            rwfa_pkg::S_SKIPD: begin
                add_a   = {2'b00, kernel_end_reg};
                add_b   = ~acc_reg;
                add_cin = 1'b1;
            end
            rwfa_pkg::S_SKIPA: begin
                add_a = {1'b0, end_reg};
                add_b = acc_reg & rwfa_pkg::PAGE_ALIGN_MASK;
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum     = add_a + add_b + rwfa_pkg::ADD_W'(add_cin);
    assign walk_end    = (cursor_reg >= count_reg);
    assign region_skip = !rd_avail_reg || (add_sum > {2'b00, rd_len_reg});
    assign page_above  = (add_sum > {2'b00, kernel_end_reg});

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rwfa_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = (s_action == rwfa_pkg::ACT_ALLOC) ?
                                 rwfa_pkg::S_CHECK : rwfa_pkg::S_DONE;
                end
            end
            rwfa_pkg::S_CHECK: state_next = walk_end ? rwfa_pkg::S_DONE : rwfa_pkg::S_LEN;
            rwfa_pkg::S_LEN:   state_next = region_skip ? rwfa_pkg::S_CHECK : rwfa_pkg::S_KERN;
            rwfa_pkg::S_KERN:  state_next = page_above ? rwfa_pkg::S_GRANT : rwfa_pkg::S_SKIPD;
            rwfa_pkg::S_GRANT: state_next = rwfa_pkg::S_DONE;
            rwfa_pkg::S_SKIPD: state_next = rwfa_pkg::S_SKIPA;
            rwfa_pkg::S_SKIPA: state_next = rwfa_pkg::S_LEN;
            rwfa_pkg::S_DONE:  state_next = out_load ? rwfa_pkg::S_IDLE : rwfa_pkg::S_DONE;
            default:           state_next = rwfa_pkg::S_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        offset_next     = offset_reg;
        end_next        = end_reg;
        acc_next        = acc_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            rwfa_pkg::S_IDLE: begin
                if (accept) begin
                    res_addr_next   = '0;
                    res_status_next = rwfa_pkg::STAT_OK;
                    unique case (s_action)
                        rwfa_pkg::ACT_CLEAR: begin
                            count_next  = '0;
                            cursor_next = '0;
                            offset_next = '0;
                        end
                        rwfa_pkg::ACT_APPEND: begin
                            if (table_full) begin
                                res_status_next = rwfa_pkg::STAT_FULL;
                            end else begin
                                count_next = count_reg + rwfa_pkg::CNT_W'(1);
                            end
                        end
                        default: begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            rwfa_pkg::S_CHECK: begin
                if (walk_end) begin
                    res_addr_next   = '0;
                    res_status_next = rwfa_pkg::STAT_OOM;
                end
            end
            rwfa_pkg::S_LEN: begin
                if (region_skip) begin
                    cursor_next = cursor_reg + rwfa_pkg::CNT_W'(1);
                    offset_next = '0;
                end else begin
                    end_next = add_sum[rwfa_pkg::OFF_W-1:0];
                end
            end
            rwfa_pkg::S_KERN: begin
                acc_next = add_sum;
            end
            rwfa_pkg::S_GRANT: begin
                res_addr_next   = add_sum[rwfa_pkg::ADDR_W-1:0];
                res_status_next = rwfa_pkg::STAT_OK;
                offset_next     = end_reg;
            end
            rwfa_pkg::S_SKIPD: begin
                acc_next = add_sum;
            end
            rwfa_pkg::S_SKIPA: begin
                offset_next = add_sum[rwfa_pkg::OFF_W-1:0];
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rwfa_pkg::S_IDLE;
            count_reg      <= '0;
            cursor_reg     <= '0;
            offset_reg     <= '0;
            kernel_end_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            offset_reg  <= offset_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                kernel_end_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        end_reg        <= end_next;
        acc_reg        <= acc_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            m_addr_reg   <= res_addr_reg;
            m_status_reg <= res_status_reg;
        end
    end

    // region table
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            base_mem[count_reg[rwfa_pkg::IDX_W-1:0]]  <= s_region_base;
            len_mem[count_reg[rwfa_pkg::IDX_W-1:0]]   <= s_region_length;
            avail_mem[count_reg[rwfa_pkg::IDX_W-1:0]] <= s_region_available;
        end
        rd_base_reg  <= base_mem[cursor_reg[rwfa_pkg::IDX_W-1:0]];
        rd_len_reg   <= len_mem[cursor_reg[rwfa_pkg::IDX_W-1:0]];
        rd_avail_reg <= avail_mem[cursor_reg[rwfa_pkg::IDX_W-1:0]];
    end

    `RWFA_ASSERT_CLK(a_cursor_in_table, cursor_reg <= count_reg, "cursor past region count")
    `RWFA_ASSERT_CLK(a_count_limit, count_reg <= rwfa_pkg::REGION_LIMIT, "region count overflow")
    `RWFA_ASSERT_CLK(a_oom_zero_addr,
        !(m_valid && (m_status != rwfa_pkg::STAT_OK) && (m_frame_address != '0)),
        "nonzero address on error")
    `RWFA_ASSERT_NEXT(a_done_delivers, out_load, m_valid && s_ready, "result not loaded")

endmodule
